/* sv/rbc_pkg.sv */
`timescale 1ns / 1ps

package rbc_pkg;

    localparam int FUNC_W    = 2;
    localparam int SEC_W     = 32;
    localparam int USEC_W    = 20;
    localparam int BYTES_W   = 32;
    localparam int VERDICT_W = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int WINDOW_W   = 16;
    localparam int INIT_W     = 24;
    localparam int MAX_WAIT_W = 25;
    localparam int WAIT_W     = 26;
    localparam int FAIL_W     = 16;

    // Event codes
    localparam logic [FUNC_W-1:0] FUNC_START      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STOP       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESCHEDULE = 2'd3;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] V_STOP    = 2'd0;
    localparam logic [VERDICT_W-1:0] V_SUCCESS = 2'd1;
    localparam logic [VERDICT_W-1:0] V_WAIT    = 2'd2;
    localparam logic [VERDICT_W-1:0] V_RESTART = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GIVE_UP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WAIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT      = 3'd4;

    // Register reset values
    localparam logic [BYTES_W-1:0]    RST_SUCCESS_BYTES = 32'd131072;
    localparam logic [WINDOW_W-1:0]   RST_CHECK_WINDOW  = 16'd15;
    localparam logic [WINDOW_W-1:0]   RST_GIVE_UP       = 16'd60;
    localparam logic [INIT_W-1:0]     RST_INITIAL_WAIT  = 24'd100000;
    localparam logic [MAX_WAIT_W-1:0] RST_MAX_WAIT      = 25'd10000000;

    localparam int USEC_PER_SEC = 1000000;

    // A second difference above this always exceeds any backoff that fits
    // the wait register, even with the worst microsecond difference.
    localparam logic [SEC_W-1:0] SEC_NEAR_MAX = 32'd68;

    localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

endpackage

/* sv/rbc_if.sv */
`timescale 1ns / 1ps

interface rbc_in_if;
    logic                          valid;
    logic                          ready;
    logic [rbc_pkg::FUNC_W-1:0]    func;
    logic [rbc_pkg::SEC_W-1:0]     now_sec;
    logic [rbc_pkg::USEC_W-1:0]    now_usec;
    logic [rbc_pkg::BYTES_W-1:0]   sent_bytes;
    logic                          allow_reschedule;

    modport source (output valid, func, now_sec, now_usec, sent_bytes,
                    allow_reschedule, input ready);
    modport sink   (input valid, func, now_sec, now_usec, sent_bytes,
                    allow_reschedule, output ready);
endinterface

interface rbc_out_if;
    logic                           valid;
    logic                           ready;
    logic [rbc_pkg::VERDICT_W-1:0]  verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

/* sv/retry_backoff_controller.sv */
`timescale 1ns / 1ps

// Retry controller with capped exponential backoff. Every event item passes
// through an input register and the compare and update logic into the state
// and the result register, so one item is taken per clock unless a check
// waits on a stalled result register. A check's verdict is presented from
// the result register once its item leaves the input register. Start and
// stop events produce no result item; restart and reschedule checks produce
// exactly one. Times are compared with wrapping 32-bit second arithmetic.
// The input side accepts while a verdict waits, until a check also waits.
// Configuration registers may be written only while no item is in flight.
module retry_backoff_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rbc_in_if.sink                           i_in,
    rbc_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rbc_pkg::*;

    localparam int ELAPSED_W = 29;

    // Configuration
    logic [BYTES_W-1:0]    r_success_bytes;
    logic [WINDOW_W-1:0]   r_check_window;
    logic [WINDOW_W-1:0]   r_give_up;
    logic [INIT_W-1:0]     r_initial_wait;
    logic [MAX_WAIT_W-1:0] r_max_wait;

    // Input register
    logic                  r_in_valid;
    logic [FUNC_W-1:0]     r_func;
    logic [SEC_W-1:0]      r_now_sec;
    logic [USEC_W-1:0]     r_now_usec;
    logic [BYTES_W-1:0]    r_sent_bytes;
    logic                  r_allow;

    // Controller state
    logic                  r_resched_en;
    logic [SEC_W-1:0]      r_start_sec;
    logic [USEC_W-1:0]     r_start_usec;
    logic [SEC_W-1:0]      r_first_retry_sec;
    logic [WAIT_W-1:0]     r_wait_us;
    logic [FAIL_W-1:0]     r_fail_cnt;

    // Result register
    logic                  r_out_valid;
    logic [VERDICT_W-1:0]  r_verdict;

    logic                  has_result;
    logic                  out_free;
    logic                  s1_go;
    logic                  in_take;

    logic [SEC_W-1:0]              d_start;
    logic [SEC_W-1:0]              d_first;
    logic                          in_window;
    logic                          give_up_passed;
    logic                          far_neg;
    logic                          far_pos;
    logic signed [ELAPSED_W-1:0]   sec_part;
    logic signed [USEC_W:0]        usec_part;
    logic signed [ELAPSED_W-1:0]   elapsed;
    logic                          before_wait;
    logic [WAIT_W-1:0]             doubled;
    logic [WAIT_W-1:0]             capped;

    logic                  n_resched_en;
    logic [SEC_W-1:0]      n_start_sec;
    logic [USEC_W-1:0]     n_start_usec;
    logic [SEC_W-1:0]      n_first_retry_sec;
    logic [WAIT_W-1:0]     n_wait_us;
    logic [FAIL_W-1:0]     n_fail_cnt;
    logic [VERDICT_W-1:0]  n_verdict;

    assign has_result = (r_func == FUNC_RESTART) || (r_func == FUNC_RESCHEDULE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_in_valid && (!has_result || out_free);
    assign i_in.ready = !r_in_valid || s1_go;
    assign in_take    = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_verdict;

    assign d_start = r_now_sec - r_start_sec;
    assign d_first = r_now_sec - r_first_retry_sec;

    assign in_window      = $signed(d_start) <= $signed({16'd0, r_check_window});
    assign give_up_passed = $signed(d_first) > $signed({16'd0, r_give_up});

    // Only second differences from -1 to SEC_NEAR_MAX need the exact
    // microsecond sum; outside that span the outcome is already known.
    assign far_neg   = d_start[SEC_W-1] && (d_start != '1);
    assign far_pos   = !d_start[SEC_W-1] && (d_start > SEC_NEAR_MAX);
    assign sec_part  = ELAPSED_W'($signed(d_start[7:0])) *
                       $signed(ELAPSED_W'(USEC_PER_SEC));
    assign usec_part = $signed({1'b0, r_now_usec}) - $signed({1'b0, r_start_usec});
    assign elapsed   = sec_part + ELAPSED_W'(usec_part);
    assign before_wait = far_neg ||
        (!far_pos && (elapsed < $signed({3'b000, r_wait_us})));

    assign doubled = {r_wait_us[WAIT_W-2:0], 1'b0};
    assign capped  = (doubled > {1'b0, r_max_wait}) ? {1'b0, r_max_wait} : doubled;

    always_comb begin
        n_resched_en      = r_resched_en;
        n_start_sec       = r_start_sec;
        n_start_usec      = r_start_usec;
        n_first_retry_sec = r_first_retry_sec;
        n_wait_us         = r_wait_us;
        n_fail_cnt        = r_fail_cnt;
        n_verdict         = V_STOP;
        unique case (r_func)
            FUNC_START: begin
                n_start_sec  = r_now_sec;
                n_start_usec = r_now_usec;
            end
            FUNC_STOP: begin
                n_resched_en = r_allow;
            end
            FUNC_RESTART: begin
                if (!r_resched_en) begin
                    n_verdict = V_STOP;
                end else if (r_sent_bytes > r_success_bytes) begin
                    n_wait_us  = WAIT_W'(r_initial_wait);
                    n_fail_cnt = '0;
                    n_verdict  = V_SUCCESS;
                end else if (in_window) begin
                    n_verdict = V_WAIT;
                end else begin
                    if (r_fail_cnt != FAIL_MAX) begin
                        n_fail_cnt = r_fail_cnt + FAIL_W'(1);
                    end
                    // The first failure marks when retrying began.
                    if (r_fail_cnt == '0) begin
                        n_first_retry_sec = r_start_sec;
                    end
                    n_verdict = V_RESTART;
                end
            end
            FUNC_RESCHEDULE: begin
                if (before_wait) begin
                    n_verdict = V_WAIT;
                end else begin
                    n_wait_us = capped;
                    if (give_up_passed && (r_fail_cnt != '0)) begin
                        n_verdict = V_STOP;
                    end else begin
                        n_verdict = V_RESTART;
                    end
                end
            end
            default: begin
                n_verdict = V_STOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_success_bytes <= RST_SUCCESS_BYTES;
            r_check_window  <= RST_CHECK_WINDOW;
            r_give_up       <= RST_GIVE_UP;
            r_initial_wait  <= RST_INITIAL_WAIT;
            r_max_wait      <= RST_MAX_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SUCCESS_BYTES: r_success_bytes <= i_cfg_data[BYTES_W-1:0];
                REG_CHECK_WINDOW:  r_check_window  <= i_cfg_data[WINDOW_W-1:0];
                REG_GIVE_UP:       r_give_up       <= i_cfg_data[WINDOW_W-1:0];
                REG_INITIAL_WAIT:  r_initial_wait  <= i_cfg_data[INIT_W-1:0];
                REG_MAX_WAIT:      r_max_wait      <= i_cfg_data[MAX_WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func       <= i_in.func;
            r_now_sec    <= i_in.now_sec;
            r_now_usec   <= i_in.now_usec;
            r_sent_bytes <= i_in.sent_bytes;
            r_allow      <= i_in.allow_reschedule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resched_en      <= 1'b1;
            r_start_sec       <= '0;
            r_start_usec      <= '0;
            r_first_retry_sec <= '0;
            r_wait_us         <= WAIT_W'(RST_INITIAL_WAIT);
            r_fail_cnt        <= '0;
        end else if (s1_go) begin
            r_resched_en      <= n_resched_en;
            r_start_sec       <= n_start_sec;
            r_start_usec      <= n_start_usec;
            r_first_retry_sec <= n_first_retry_sec;
            r_wait_us         <= n_wait_us;
            r_fail_cnt        <= n_fail_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && has_result) begin
            r_verdict <= n_verdict;
        end
    end

    // A check that leaves the input register always lands a verdict.
    a_check_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && has_result) |=> r_out_valid)
        else $error("check item left the input register without a verdict");

    // The failure count only steps up by one or clears.
    a_fail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fail_cnt != $past(r_fail_cnt))) |->
        ((r_fail_cnt == $past(r_fail_cnt) + FAIL_W'(1)) || (r_fail_cnt == '0)))
        else $error("failure count moved other than by one or to zero");

    // A doubled backoff never exceeds the cap.
    a_wait_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_func == FUNC_RESCHEDULE) && !before_wait) |=>
        (r_wait_us <= {1'b0, r_max_wait}))
        else $error("backoff wait above its cap");

    // A restart check while rescheduling is off reports stop.
    a_disabled_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_func == FUNC_RESTART) && !r_resched_en) |=>
        (r_verdict == V_STOP))
        else $error("disabled restart check did not report stop");

    // A pending verdict is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(s1_go && has_result))
        else $error("verdict overwritten while stalled");

endmodule
